// ===== rtl/dff_pkg.sv =====
`default_nettype none

package dff_pkg;

  // frame layout
  localparam int unsigned POS_W       = 5;
  localparam int unsigned POS_MAX     = 31;
  localparam int unsigned HDR_LEN     = 24;
  localparam int unsigned FCS_LEN     = 4;
  localparam int unsigned ALERT_POS   = HDR_LEN + FCS_LEN - 1;
  localparam int unsigned DEST_FIRST  = 4;
  localparam int unsigned DEST_LAST   = 9;
  localparam int unsigned BSSID_FIRST = 10;
  localparam int unsigned BSSID_LAST  = 15;
  localparam int unsigned SRC_FIRST   = 16;
  localparam int unsigned SRC_LAST    = 21;

  // frame control byte
  localparam logic [7:0] TYPE_MASK      = 8'h0C;
  localparam logic [7:0] SUBTYPE_MASK   = 8'hF0;
  localparam logic [3:0] TYPE_MGMT      = 4'h0;
  localparam logic [3:0] SUBTYPE_DEAUTH = 4'hC;

  localparam int unsigned MAC_W  = 48;
  localparam int unsigned CHAN_W = 4;

  // alert queue, depth must be a power of two
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // register map
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 64;
  localparam logic        REG_TARGET = 1'b0;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              last_byte;
    logic              is_management;
    logic [CHAN_W-1:0] channel;
  } in_t;

  typedef struct packed {
    logic [MAC_W-1:0]  source_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [MAC_W-1:0]  alert_bssid;
    logic [CHAN_W-1:0] alert_channel;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t item;
  } alert_t;

  function automatic logic is_deauth(input logic [7:0] fc);
    logic [7:0] t;
    logic [7:0] s;
    t = (fc & TYPE_MASK) >> 2;
    s = (fc & SUBTYPE_MASK) >> 4;
    return (t[3:0] == TYPE_MGMT) && (s[3:0] == SUBTYPE_DEAUTH);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dff_front.sv =====
`default_nettype none

module dff_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire dff_pkg::in_t             item,
  input  wire logic [dff_pkg::MAC_W-1:0] target,
  output dff_pkg::alert_t               push
);

  logic [dff_pkg::POS_W-1:0] pos;
  logic                      frame_is_mgmt;
  logic                      header_is_deauth;
  logic                      bssid_matches;
  logic [dff_pkg::MAC_W-1:0] dest_store;
  logic [dff_pkg::MAC_W-1:0] source_store;

  logic       in_dest;
  logic       in_bssid;
  logic       in_src;
  logic [2:0] bsel;
  logic [7:0] want;

  assign in_dest  = (pos >= dff_pkg::POS_W'(dff_pkg::DEST_FIRST)) &&
                    (pos <= dff_pkg::POS_W'(dff_pkg::DEST_LAST));
  assign in_bssid = (pos >= dff_pkg::POS_W'(dff_pkg::BSSID_FIRST)) &&
                    (pos <= dff_pkg::POS_W'(dff_pkg::BSSID_LAST));
  assign in_src   = (pos >= dff_pkg::POS_W'(dff_pkg::SRC_FIRST)) &&
                    (pos <= dff_pkg::POS_W'(dff_pkg::SRC_LAST));

  // first bssid byte is the most significant one
  assign bsel = 3'(dff_pkg::POS_W'(dff_pkg::BSSID_LAST) - pos);
  assign want = 8'(target >> {bsel, 3'b000});

  always_ff @(posedge clk) begin
    if (rst) begin
      pos              <= '0;
      frame_is_mgmt    <= 1'b0;
      header_is_deauth <= 1'b0;
      bssid_matches    <= 1'b1;
    end else if (accept) begin
      if (pos == '0) begin
        frame_is_mgmt    <= item.is_management;
        header_is_deauth <= dff_pkg::is_deauth(item.data_byte);
        bssid_matches    <= 1'b1;
      end else if (in_bssid && (want != item.data_byte)) begin
        bssid_matches <= 1'b0;
      end
      if (item.last_byte) begin
        pos <= '0;
      end else if (pos < dff_pkg::POS_W'(dff_pkg::POS_MAX)) begin
        pos <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_dest) begin
      dest_store <= {dest_store[dff_pkg::MAC_W-9:0], item.data_byte};
    end
    if (accept && in_src) begin
      source_store <= {source_store[dff_pkg::MAC_W-9:0], item.data_byte};
    end
  end

  // flags are settled long before the alert position
  always_comb begin
    push.valid              = accept && item.last_byte && frame_is_mgmt &&
                              header_is_deauth && bssid_matches &&
                              (pos >= dff_pkg::POS_W'(dff_pkg::ALERT_POS));
    push.item.source_mac    = source_store;
    push.item.dst_mac       = dest_store;
    push.item.alert_bssid   = target;
    push.item.alert_channel = item.channel;
  end

`ifndef ASSERT_OFF
  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && item.last_byte) |=> (pos == '0))
    else $error("byte position not restarted after frame end");

  a_alert_long: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (pos >= dff_pkg::POS_W'(dff_pkg::ALERT_POS)) && frame_is_mgmt)
    else $error("alert raised for short or non-management frame");
`endif

endmodule

`default_nettype wire

// ===== rtl/dff_queue.sv =====
`default_nettype none

module dff_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dff_pkg::alert_t push,
  input  wire logic            pop,
  output logic                 full,
  output dff_pkg::alert_t      head
);

  dff_pkg::out_t             mem [dff_pkg::QDEPTH];
  logic [dff_pkg::QAW-1:0]   wptr;
  logic [dff_pkg::QAW-1:0]   rptr;
  logic [dff_pkg::QCW-1:0]   count;
  logic [dff_pkg::QCW-1:0]   count_next;

  assign full       = (count == dff_pkg::QCW'(dff_pkg::QDEPTH));
  assign head.valid = (count != '0);
  assign head.item  = mem[rptr];

  always_comb begin
    count_next = count;
    if (push.valid && !pop) begin
      count_next = count + 1'b1;
    end else if (!push.valid && pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push.valid) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wptr] <= push.item;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("alert queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("alert queue underflow");
`endif

endmodule

`default_nettype wire

// ===== rtl/dff_back.sv =====
`default_nettype none

module dff_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dff_pkg::alert_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output dff_pkg::out_t        out_item
);

  assign pop = head.valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= head.item;
    end
  end

`ifndef ASSERT_OFF
  a_load_after_pop: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("output register not loaded after queue pop");
`endif

endmodule

`default_nettype wire

// ===== rtl/deauth_frame_filter.sv =====
`default_nettype none

// Deauthentication frame filter. Takes a received 802.11 frame one byte per
// transaction on the input channel, FCS included, with last_byte set on the
// final byte. Byte 0 is checked for a management deauthentication frame
// control field, the destination (bytes 4-9) and source (bytes 16-21) are
// captured, and the BSSID (bytes 10-15) is compared byte by byte against
// watch_bssid. When a frame that was flagged management at byte 0, is
// deauthentication, matches the watched BSSID and is at least 28 bytes long
// ends, one alert transaction appears on the output channel carrying source,
// destination, the watched BSSID and the channel seen with the last byte.
// Rate: one byte per clock while in_ready is high, with no gaps between frames.
// An alert is decided combinationally by the front end and enters the queue at
// the edge that takes its last byte; it then moves into the output register
// once that register is empty or being taken by out_ready.
// in_ready only drops while the four-entry alert queue is full, which takes
// four alerts held back by out_ready on top of the one in the output
// register. watch_bssid sits at byte address 0 of the APB port (64-bit
// data, low 48 bits used); change it only while no frame is in progress.
module deauth_frame_filter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // byte stream
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire dff_pkg::in_t                in_item,
  // alerts
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output dff_pkg::out_t                    out_item,
  // register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dff_pkg::PADDR_W-1:0] paddr,
  input  wire logic [dff_pkg::PDATA_W-1:0] pwdata,
  output logic [dff_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  logic [dff_pkg::MAC_W-1:0] watch_bssid;
  logic                      q_full;
  logic                      q_pop;
  logic                      accept;
  dff_pkg::alert_t           push;
  dff_pkg::alert_t           head;

  // register port, word select on bit 3, byte offset ignored
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      watch_bssid <= '0;
    end else if (psel && penable && pwrite && (paddr[3] == dff_pkg::REG_TARGET)) begin
      watch_bssid <= pwdata[dff_pkg::MAC_W-1:0];
    end
  end

  always_comb begin
    if (paddr[3] == dff_pkg::REG_TARGET) begin
      prdata = dff_pkg::PDATA_W'(watch_bssid);
    end else begin
      prdata = '0;
    end
  end

  // input side only waits on a full alert queue
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // front end: byte position, header flags, address capture
  dff_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_item),
    .target (watch_bssid),
    .push   (push)
  );

  // pending alerts between front and back
  dff_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (q_pop),
    .full (q_full),
    .head (head)
  );

  // back end: output register toward the consumer
  dff_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // run length and safety limits
  localparam int unsigned RAND_ITEMS = 1130;  // random bytes to send
  localparam int unsigned DRAIN      = 8;     // quiet cycles, alert path is the queue and the output register
  localparam int unsigned LIMIT      = 400000;
  localparam logic [dff_pkg::MAC_W-1:0] ONES = 48'hFFFF_FFFF_FFFF;
  localparam logic [dff_pkg::MAC_W-1:0] ZERO = 48'h0;
  localparam logic [dff_pkg::PADDR_W-1:0] TARGET_ADDR =
    dff_pkg::PADDR_W'(8 * dff_pkg::REG_TARGET);

  // how a directed frame is checked
  typedef enum logic [1:0] {
    CHK_PREDICT,  // result from the predictor
    CHK_SILENT,   // typed in: no alert
    CHK_ALERT     // typed in: the alert in the row
  } row_chk_t;

  typedef struct packed {
    logic                      write_cfg;  // program the watched bssid before the frame
    logic [dff_pkg::MAC_W-1:0] cfg_value;
    logic [7:0]                len;
    logic [7:0]                fc;
    logic                      mgmt;
    logic [dff_pkg::MAC_W-1:0] dest;
    logic [dff_pkg::MAC_W-1:0] bssid;
    logic [dff_pkg::MAC_W-1:0] src;
    logic [3:0]                chan;
    row_chk_t                  chk;
    dff_pkg::out_t             want;
  } frame_row_t;

  localparam int unsigned NDIR = 15;
  localparam frame_row_t DIR_ROWS [NDIR] = '{
    // minimum length deauth, target still at reset value
    '{1'b0, ZERO, 8'd28, 8'hC0, 1'b1, ONES, ZERO, ONES, 4'hF, CHK_ALERT,
      '{ONES, ONES, ZERO, 4'hF}},
    // one byte short of the minimum length
    '{1'b0, ZERO, 8'd27, 8'hC0, 1'b1, ONES, ZERO, ONES, 4'hF, CHK_SILENT, '0},
    // receiver did not flag management
    '{1'b0, ZERO, 8'd28, 8'hC0, 1'b0, ONES, ZERO, ONES, 4'h1, CHK_SILENT, '0},
    // authentication subtype
    '{1'b0, ZERO, 8'd28, 8'hB0, 1'b1, ONES, ZERO, ONES, 4'h2, CHK_SILENT, '0},
    // control type bits
    '{1'b0, ZERO, 8'd28, 8'hC4, 1'b1, ONES, ZERO, ONES, 4'h3, CHK_SILENT, '0},
    // data type bits
    '{1'b0, ZERO, 8'd28, 8'hC8, 1'b1, ONES, ZERO, ONES, 4'h4, CHK_SILENT, '0},
    // bssid mismatch in its last byte
    '{1'b0, ZERO, 8'd28, 8'hC0, 1'b1, ONES, 48'h0000_0000_0001, ONES, 4'h5,
      CHK_SILENT, '0},
    // bssid mismatch in its first byte
    '{1'b0, ZERO, 8'd28, 8'hC0, 1'b1, ONES, 48'h8000_0000_0000, ONES, 4'h6,
      CHK_SILENT, '0},
    // long frame, position saturates, low fc bits set
    '{1'b0, ZERO, 8'd45, 8'hC3, 1'b1, ZERO, ZERO, ZERO, 4'h0, CHK_ALERT,
      '{ZERO, ZERO, ZERO, 4'h0}},
    // single byte frame
    '{1'b0, ZERO, 8'd1, 8'hC0, 1'b1, ZERO, ZERO, ZERO, 4'h7, CHK_SILENT, '0},
    '{1'b0, ZERO, 8'd32, 8'hC1, 1'b1, 48'h0123_4567_89AB, ZERO, 48'hFEDC_BA98_7654,
      4'h9, CHK_PREDICT, '0},
    '{1'b0, ZERO, 8'd31, 8'hC2, 1'b1, 48'h5555_AAAA_5555, ZERO, 48'hAAAA_5555_AAAA,
      4'h3, CHK_PREDICT, '0},
    // all-ones target
    '{1'b1, ONES, 8'd28, 8'hC0, 1'b1, 48'h0123_4567_89AB, ONES, 48'hBA98_7654_3210,
      4'h6, CHK_ALERT, '{48'hBA98_7654_3210, 48'h0123_4567_89AB, ONES, 4'h6}},
    '{1'b0, ZERO, 8'd29, 8'hC0, 1'b1, ONES, ZERO, ONES, 4'h8, CHK_SILENT, '0},
    '{1'b0, ZERO, 8'd33, 8'hC0, 1'b1, 48'h1122_3344_5566, ONES, 48'h6655_4433_2211,
      4'hC, CHK_PREDICT, '0}
  };

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // dut ports, inputs all known from time zero
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  dff_pkg::in_t                  in_item   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  dff_pkg::out_t                 out_item;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [dff_pkg::PADDR_W-1:0]   paddr     = '0;
  logic [dff_pkg::PDATA_W-1:0]   pwdata    = '0;
  logic [dff_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  // filter state mirrored on the testbench side
  logic [dff_pkg::POS_W-1:0] frame_pos     = '0;
  logic                      frame_mgmt    = 1'b0;
  logic                      frame_deauth  = 1'b0;
  logic                      bssid_ok      = 1'b1;
  logic [dff_pkg::MAC_W-1:0] dest_addr     = '0;
  logic [dff_pkg::MAC_W-1:0] src_addr      = '0;
  logic [dff_pkg::MAC_W-1:0] watched_bssid = '0;

  // alerts still to come out of the dut, oldest first
  dff_pkg::out_t alerts_due [$];
  dff_pkg::in_t  frame_bytes [$];

  int unsigned errors       = 0;
  int unsigned items_sent   = 0;
  int unsigned cycles       = 0;
  int unsigned send_idle    = 0;  // percent of cycles the sender holds off
  int unsigned recv_idle    = 0;  // percent of cycles the receiver stalls

  deauth_frame_filter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one accepted byte through the filter state, 1 when the frame raises an alert
  function automatic bit deauth_check_byte(input dff_pkg::in_t b,
                                           output dff_pkg::out_t alert);
    bit fire;
    fire  = 1'b0;
    alert = '0;
    if (frame_pos == 0) begin
      // frame control: management type, deauthentication subtype
      frame_mgmt   = b.is_management;
      frame_deauth = ((b.data_byte & dff_pkg::TYPE_MASK) == 8'h00) &&
                     (b.data_byte[7:4] == dff_pkg::SUBTYPE_DEAUTH);
      bssid_ok     = 1'b1;
    end else if (frame_pos >= dff_pkg::DEST_FIRST && frame_pos <= dff_pkg::DEST_LAST) begin
      dest_addr = {dest_addr[dff_pkg::MAC_W-9:0], b.data_byte};
    end else if (frame_pos >= dff_pkg::BSSID_FIRST && frame_pos <= dff_pkg::BSSID_LAST) begin
      if (watched_bssid[8 * (dff_pkg::BSSID_LAST - frame_pos) +: 8] != b.data_byte)
        bssid_ok = 1'b0;
    end else if (frame_pos >= dff_pkg::SRC_FIRST && frame_pos <= dff_pkg::SRC_LAST) begin
      src_addr = {src_addr[dff_pkg::MAC_W-9:0], b.data_byte};
    end
    if (b.last_byte) begin
      if (frame_mgmt && frame_deauth && bssid_ok && frame_pos >= dff_pkg::ALERT_POS) begin
        fire                = 1'b1;
        alert.source_mac    = src_addr;
        alert.dst_mac       = dest_addr;
        alert.alert_bssid   = watched_bssid;
        alert.alert_channel = b.channel;
      end
      frame_pos = '0;
    end else if (frame_pos != dff_pkg::POS_MAX) begin
      frame_pos = frame_pos + 1'b1;
    end
    return fire;
  endfunction

  // lay out one frame, filler bytes and metadata random
  task automatic build_frame(input int unsigned len, input logic [7:0] fc,
                             input logic mgmt, input logic [dff_pkg::MAC_W-1:0] dest,
                             input logic [dff_pkg::MAC_W-1:0] bssid,
                             input logic [dff_pkg::MAC_W-1:0] src,
                             input logic [3:0] chan);
    dff_pkg::in_t b;
    frame_bytes.delete();
    for (int unsigned i = 0; i < len; i++) begin
      b.data_byte     = 8'($urandom);
      b.is_management = (i == 0) ? mgmt : 1'($urandom);
      b.last_byte     = (i == len - 1);
      b.channel       = b.last_byte ? chan : 4'($urandom);
      if (i == 0)
        b.data_byte = fc;
      else if (i >= dff_pkg::DEST_FIRST && i <= dff_pkg::DEST_LAST)
        b.data_byte = dest[8 * (dff_pkg::DEST_LAST - i) +: 8];
      else if (i >= dff_pkg::BSSID_FIRST && i <= dff_pkg::BSSID_LAST)
        b.data_byte = bssid[8 * (dff_pkg::BSSID_LAST - i) +: 8];
      else if (i >= dff_pkg::SRC_FIRST && i <= dff_pkg::SRC_LAST)
        b.data_byte = src[8 * (dff_pkg::SRC_LAST - i) +: 8];
      frame_bytes.push_back(b);
    end
  endtask

  // push the frame through the input channel; typed rows override the predictor
  task automatic send_frame(input bit typed, input bit typed_fire,
                            input dff_pkg::out_t typed_alert);
    dff_pkg::out_t alert;
    bit            fire;
    foreach (frame_bytes[i]) begin
      // random hold-off before this transaction
      while ($urandom_range(0, 99) < send_idle) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_item  <= frame_bytes[i];
      in_valid <= 1'b1;
      do @(posedge clk); while (!in_ready);
      fire = deauth_check_byte(frame_bytes[i], alert);
      if (typed) begin
        fire  = typed_fire && frame_bytes[i].last_byte;
        alert = typed_alert;
      end
      if (fire) begin
        alerts_due.push_back(alert);
      end
      items_sent++;
    end
  endtask

  // let the block go quiet, then program the watched bssid over apb
  task automatic set_target(input logic [dff_pkg::MAC_W-1:0] value);
    in_valid <= 1'b0;
    while (alerts_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    // setup phase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TARGET_ADDR;
    pwdata  <= dff_pkg::PDATA_W'(value);
    @(posedge clk);
    // access phase
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    watched_bssid = value;
  endtask

  task automatic cmp_field(input string name, input logic [dff_pkg::MAC_W-1:0] want,
                           input logic [dff_pkg::MAC_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // receiver: random stalls on out_ready
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // scoreboard: every alert transaction against the oldest one due
  always @(posedge clk) begin : alert_check
    dff_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (alerts_due.size() == 0) begin
        $display("%0t: unexpected alert, expected none, actual %h", $time, out_item);
        errors++;
      end else begin
        want = alerts_due.pop_front();
        cmp_field("source_mac", want.source_mac, out_item.source_mac);
        cmp_field("dst_mac", want.dst_mac, out_item.dst_mac);
        cmp_field("alert_bssid", want.alert_bssid, out_item.alert_bssid);
        cmp_field("alert_channel", dff_pkg::MAC_W'(want.alert_channel),
                  dff_pkg::MAC_W'(out_item.alert_channel));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned               kind;
    int unsigned               len;
    int unsigned               k;
    logic [7:0]                fc;
    logic                      mgmt;
    logic [dff_pkg::MAC_W-1:0] dest;
    logic [dff_pkg::MAC_W-1:0] bssid;
    logic [dff_pkg::MAC_W-1:0] src;
    logic [3:0]                chan;
    logic [dff_pkg::MAC_W-1:0] phase_target;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed frames, first idle mix
    send_idle = 32;
    recv_idle = 77;
    for (int r = 0; r < NDIR; r++) begin
      if (DIR_ROWS[r].write_cfg) set_target(DIR_ROWS[r].cfg_value);
      build_frame(32'(DIR_ROWS[r].len), DIR_ROWS[r].fc, DIR_ROWS[r].mgmt,
                  DIR_ROWS[r].dest, DIR_ROWS[r].bssid, DIR_ROWS[r].src,
                  DIR_ROWS[r].chan);
      send_frame(DIR_ROWS[r].chk != CHK_PREDICT, DIR_ROWS[r].chk == CHK_ALERT,
                 DIR_ROWS[r].want);
    end

    // random frames in three phases: receiver stalls most, sender idles most, neither
    items_sent = 0;
    for (int p = 0; p < 3; p++) begin
      phase_target = (p == 1) ? ONES : 48'({$urandom(), $urandom()});
      set_target(phase_target);
      send_idle = (p == 0) ? 32 : (p == 1) ? 77 : 0;
      recv_idle = (p == 0) ? 77 : (p == 1) ? 32 : 0;
      while (items_sent < RAND_ITEMS * (p + 1) / 3) begin
        // start from a well-formed deauth aimed at the target
        kind  = $urandom_range(0, 99);
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(32, 48) : $urandom_range(28, 31);
        fc    = {dff_pkg::SUBTYPE_DEAUTH, 2'b00, 2'($urandom)};
        mgmt  = 1'b1;
        dest  = 48'({$urandom(), $urandom()});
        bssid = watched_bssid;
        src   = 48'({$urandom(), $urandom()});
        chan  = 4'($urandom);
        // then break a third of them in one way or another
        if (kind >= 93) begin
          len   = $urandom_range(1, 48);
          fc    = 8'($urandom);
          mgmt  = 1'($urandom);
          bssid = 48'({$urandom(), $urandom()});
        end else if (kind >= 86) begin
          k = $urandom_range(0, 5);
          bssid[8 * k +: 8] = bssid[8 * k +: 8] ^ 8'($urandom_range(1, 255));
        end else if (kind >= 79) begin
          fc = 8'($urandom);
        end else if (kind >= 72) begin
          mgmt = 1'b0;
        end else if (kind >= 65) begin
          len = $urandom_range(1, 27);
        end
        build_frame(len, fc, mgmt, dest, bssid, src, chan);
        send_frame(1'b0, 1'b0, '0);
      end
    end

    // wait out the last alerts, then a few quiet cycles for strays
    in_valid <= 1'b0;
    while (alerts_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
